@@ rtl/rwl_pkg.sv @@
// Shared types, codes and defaults for the reader-writer lock manager.
package rwl_pkg;

  localparam int WAIT_DEPTH_DEF     = 16;
  localparam int THREAD_ID_BITS_DEF = 8;
  localparam int COUNT_BITS_DEF     = 16;

  localparam logic [2:0] F_LOCK_SH = 3'd0;
  localparam logic [2:0] F_LOCK_EX = 3'd1;
  localparam logic [2:0] F_UNLOCK  = 3'd2;
  localparam logic [2:0] F_FORCE   = 3'd3;
  localparam logic [2:0] F_RESTORE = 3'd4;

  localparam logic [2:0] EV_GRANTED  = 3'd0;
  localparam logic [2:0] EV_BLOCKED  = 3'd1;
  localparam logic [2:0] EV_RELEASED = 3'd2;
  localparam logic [2:0] EV_WOKEN    = 3'd3;
  localparam logic [2:0] EV_REJECTED = 3'd4;
  localparam logic [2:0] EV_FORCE    = 3'd5;

  localparam logic [1:0] M_UNLOCKED = 2'd0;
  localparam logic [1:0] M_SHARED   = 2'd1;
  localparam logic [1:0] M_EXCL     = 2'd2;

  typedef struct packed {
    logic [2:0]                    func;
    logic [THREAD_ID_BITS_DEF-1:0] thread_id;
    logic [COUNT_BITS_DEF-1:0]     restore_count;
  } req_t;

  typedef struct packed {
    logic [THREAD_ID_BITS_DEF-1:0] target_thread;
    logic [2:0]                    event_res;
    logic [1:0]                    mode_after;
    logic [COUNT_BITS_DEF-1:0]     count;
    logic                          last;
  } res_t;

  typedef struct packed {
    logic [THREAD_ID_BITS_DEF-1:0] thread;
    logic [COUNT_BITS_DEF-1:0]     cnt;
  } entry_t;

  typedef struct packed {
    logic accept;
    logic scan_run;
    logic decide;
    logic wake_out;
  } cmd_t;

  typedef struct packed {
    logic scan_done;
    logic wake_any;
    logic wake_more;
    logic out_free;
  } stat_t;

endpackage

@@ rtl/rwl_stream_if.sv @@
// Valid/ready stream channel carrying one payload type.
interface rwl_stream_if #(parameter type T = logic) ();
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

@@ rtl/rwl_ctrl.sv @@
// Sequencer for one request: waiter scan, decision, wake walk.
module rwl_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  output logic          req_ready,
  input  rwl_pkg::stat_t st,
  output rwl_pkg::cmd_t  cmd
);

  typedef enum logic [4:0] {
    S_IDLE   = 5'b00001,
    S_SCAN   = 5'b00010,
    S_DECIDE = 5'b00100,
    S_WRD    = 5'b01000,
    S_WOUT   = 5'b10000
  } state_t;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    req_ready  = 1'b0;
    case (state)
      S_IDLE: begin
        req_ready = 1'b1;
        if (req_valid) begin
          cmd.accept = 1'b1;
          state_next = S_SCAN;
        end
      end
      S_SCAN: begin
        cmd.scan_run = 1'b1;
        if (st.scan_done) state_next = S_DECIDE;
      end
      S_DECIDE: begin
        // hold until the output register can take the first result
        if (st.out_free) begin
          cmd.decide = 1'b1;
          state_next = st.wake_any ? S_WRD : S_IDLE;
        end
      end
      S_WRD: begin
        state_next = S_WOUT;
      end
      S_WOUT: begin
        if (st.out_free) begin
          cmd.wake_out = 1'b1;
          state_next   = st.wake_more ? S_WRD : S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

@@ rtl/rwl_datapath.sv @@
// Lock state, wait queues, waiter scan, decision logic and output register.
module rwl_datapath #(
  parameter int WAIT_DEPTH = rwl_pkg::WAIT_DEPTH_DEF
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           cfg_we,
  input  logic           cfg_wdata,
  input  rwl_pkg::req_t  req_data,
  input  logic           res_ready,
  output logic           res_valid,
  output rwl_pkg::res_t  res_data,
  input  rwl_pkg::cmd_t  cmd,
  output rwl_pkg::stat_t st
);

  localparam int THREAD_ID_BITS = rwl_pkg::THREAD_ID_BITS_DEF;
  localparam int COUNT_BITS     = rwl_pkg::COUNT_BITS_DEF;
  localparam int AW = (WAIT_DEPTH > 1) ? $clog2(WAIT_DEPTH) : 1;
  localparam int CW = $clog2(WAIT_DEPTH + 1);
  localparam int SW = $clog2(2 * WAIT_DEPTH + 1);
  localparam int TidMax = (1 << THREAD_ID_BITS) - 1;
  localparam logic [32:0] CntMax = (33'd1 << COUNT_BITS) - 33'd1;

  logic                      big;
  rwl_pkg::req_t             req;
  logic [1:0]                lmode;
  logic [THREAD_ID_BITS-1:0] owner;
  logic [COUNT_BITS-1:0]     rec, shr;
  logic [AW-1:0]             ehead;
  logic [CW-1:0]             ecnt, scnt;

  rwl_pkg::entry_t sh_mem [WAIT_DEPTH];
  rwl_pkg::entry_t ex_mem [WAIT_DEPTH];
  rwl_pkg::entry_t sh_rd, ex_rd;
  logic [AW-1:0]   sh_raddr, ex_raddr;

  logic [SW-1:0] scan_j;
  logic          pend, pend_sh, found;
  logic          wk_sh, wk_ex;
  logic [AW-1:0] widx;
  logic [1:0]    mode_out;
  logic          out_v;
  rwl_pkg::res_t out_d;

  function automatic logic [AW-1:0] wrap(input logic [AW:0] s);
    if (s >= (AW+1)'(WAIT_DEPTH)) wrap = AW'(s - (AW+1)'(WAIT_DEPTH));
    else wrap = s[AW-1:0];
  endfunction

  // waiter scan: shared entries first, then the exclusive ring
  logic [SW-1:0] total, eoff;
  logic          issuing, issue_sh;
  logic [AW-1:0] scan_sh_addr, scan_ex_addr;

  always_comb begin
    total        = SW'(scnt) + SW'(ecnt);
    issuing      = cmd.scan_run && (scan_j < total);
    issue_sh     = scan_j < SW'(scnt);
    eoff         = scan_j - SW'(scnt);
    scan_sh_addr = issue_sh ? scan_j[AW-1:0] : '0;
    scan_ex_addr = wrap({1'b0, ehead} + eoff[AW:0]);
    sh_raddr     = cmd.scan_run ? scan_sh_addr : widx;
    ex_raddr     = cmd.scan_run ? scan_ex_addr : ehead;
  end

  // decision
  logic [32:0]               rec33, shr33, lc33, n_rec, n_shr, rcnt;
  logic [1:0]                n_mode, mode_after;
  logic [THREAD_ID_BITS-1:0] n_owner;
  logic                      rej, enq_sh, enq_ex, do_wake, prev_excl, want_ex;
  logic                      wk_sh_c, wk_ex_c, sh_full, ex_full, tid_bad;
  logic [2:0]                ev;
  logic [COUNT_BITS-1:0]     enq_cnt;

  always_comb begin
    rec33     = 33'(rec);
    shr33     = 33'(shr);
    lc33      = 33'(req.restore_count);
    sh_full   = scnt == CW'(WAIT_DEPTH);
    ex_full   = ecnt == CW'(WAIT_DEPTH);
    tid_bad   = (req.thread_id == '0) || (int'(req.thread_id) > TidMax) || found;
    want_ex   = req.func == rwl_pkg::F_LOCK_EX;
    rej       = 1'b0;
    ev        = rwl_pkg::EV_GRANTED;
    rcnt      = '0;
    n_mode    = lmode;
    n_owner   = owner;
    n_rec     = rec33;
    n_shr     = shr33;
    enq_sh    = 1'b0;
    enq_ex    = 1'b0;
    enq_cnt   = COUNT_BITS'(1);
    do_wake   = 1'b0;
    prev_excl = 1'b0;
    if (tid_bad) begin
      rej = 1'b1;
    end else begin
      case (req.func)
        rwl_pkg::F_LOCK_SH, rwl_pkg::F_LOCK_EX: begin
          if (!want_ex && big) begin
            rej = 1'b1;
          end else if (lmode == rwl_pkg::M_UNLOCKED) begin
            n_mode  = want_ex ? rwl_pkg::M_EXCL : rwl_pkg::M_SHARED;
            n_owner = want_ex ? req.thread_id : '0;
            n_shr   = want_ex ? 33'd0 : 33'd1;
            n_rec   = 33'd1;
            rcnt    = 33'd1;
          end else if (lmode == rwl_pkg::M_EXCL && owner == req.thread_id) begin
            if (rec33 >= CntMax) rej = 1'b1;
            n_rec = rec33 + 33'd1;
            rcnt  = n_rec;
          end else if (lmode == rwl_pkg::M_SHARED && !want_ex) begin
            if (rec33 >= CntMax || shr33 >= CntMax) rej = 1'b1;
            n_rec = rec33 + 33'd1;
            n_shr = shr33 + 33'd1;
            rcnt  = n_rec;
          end else begin
            ev   = rwl_pkg::EV_BLOCKED;
            rcnt = 33'd1;
            if (!want_ex) begin
              enq_sh = 1'b1;
              rej    = sh_full;
            end else begin
              enq_ex = 1'b1;
              rej    = ex_full;
            end
          end
        end
        rwl_pkg::F_UNLOCK: begin
          if (lmode == rwl_pkg::M_UNLOCKED ||
              (lmode == rwl_pkg::M_EXCL && owner != req.thread_id)) begin
            rej = 1'b1;
          end else begin
            prev_excl = lmode == rwl_pkg::M_EXCL;
            ev        = rwl_pkg::EV_RELEASED;
            if (rec33 != 33'd0) n_rec = rec33 - 33'd1;
            if (!prev_excl && shr33 != 33'd0) n_shr = shr33 - 33'd1;
            rcnt = n_rec;
            if (n_rec == 33'd0) begin
              n_owner = '0;
              n_shr   = 33'd0;
              n_mode  = rwl_pkg::M_UNLOCKED;
              do_wake = 1'b1;
            end
          end
        end
        rwl_pkg::F_FORCE: begin
          if (!big || lmode == rwl_pkg::M_SHARED) begin
            rej = 1'b1;
          end else begin
            ev = rwl_pkg::EV_FORCE;
            if (lmode == rwl_pkg::M_EXCL && owner == req.thread_id) begin
              rcnt      = rec33;
              n_owner   = '0;
              n_rec     = 33'd0;
              n_mode    = rwl_pkg::M_UNLOCKED;
              do_wake   = 1'b1;
              prev_excl = 1'b1;
            end
          end
        end
        rwl_pkg::F_RESTORE: begin
          if (!big || lc33 == 33'd0 || lc33 > CntMax || lmode == rwl_pkg::M_SHARED) begin
            rej = 1'b1;
          end else if (lmode == rwl_pkg::M_UNLOCKED) begin
            n_mode  = rwl_pkg::M_EXCL;
            n_owner = req.thread_id;
            n_shr   = 33'd0;
            n_rec   = lc33;
            rcnt    = lc33;
          end else if (owner == req.thread_id) begin
            n_rec = rec33 + lc33;
            rcnt  = n_rec;
            if (n_rec > CntMax) rej = 1'b1;
          end else begin
            ev      = rwl_pkg::EV_BLOCKED;
            rcnt    = lc33;
            enq_ex  = 1'b1;
            enq_cnt = req.restore_count;
            rej     = ex_full;
          end
        end
        default: begin
          rej = 1'b1;
        end
      endcase
    end

    wk_sh_c = 1'b0;
    wk_ex_c = 1'b0;
    if (do_wake && !rej) begin
      if (big) begin
        wk_ex_c = ecnt != '0;
      end else if (prev_excl) begin
        wk_sh_c = scnt != '0;
        wk_ex_c = (scnt == '0) && (ecnt != '0);
      end else begin
        wk_ex_c = ecnt != '0;
        wk_sh_c = (ecnt == '0) && (scnt != '0);
      end
    end
    if (rej) mode_after = lmode;
    else if (wk_sh_c) mode_after = rwl_pkg::M_SHARED;
    else if (wk_ex_c) mode_after = rwl_pkg::M_EXCL;
    else mode_after = n_mode;
  end

  // shared wake sums saturate
  logic [32:0]     sum_rec, sum_shr;
  rwl_pkg::entry_t wentry;
  logic            sh_last;

  always_comb begin
    wentry  = wk_ex ? ex_rd : sh_rd;
    sum_rec = rec33 + 33'(sh_rd.cnt);
    sum_shr = shr33 + 33'(sh_rd.cnt);
    if (sum_rec > CntMax) sum_rec = CntMax;
    if (sum_shr > CntMax) sum_shr = CntMax;
    sh_last = (CW'(widx) + CW'(1)) == scnt;
  end

  always_ff @(posedge clk) begin
    sh_rd <= sh_mem[sh_raddr];
    ex_rd <= ex_mem[ex_raddr];
    if (cmd.decide && !rej && enq_sh) begin
      sh_mem[scnt[AW-1:0]] <= '{thread: req.thread_id, cnt: enq_cnt};
    end
    if (cmd.decide && !rej && enq_ex) begin
      ex_mem[wrap({1'b0, ehead} + (AW+1)'(ecnt))] <= '{thread: req.thread_id, cnt: enq_cnt};
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      req    <= req_data;
      scan_j <= '0;
      found  <= 1'b0;
    end else if (issuing) begin
      scan_j <= scan_j + SW'(1);
    end
    pend_sh <= issue_sh;
    if (pend && !cmd.accept) begin
      if ((pend_sh ? sh_rd.thread : ex_rd.thread) == req.thread_id) found <= 1'b1;
    end
    if (cmd.decide) begin
      wk_sh    <= wk_sh_c;
      wk_ex    <= wk_ex_c;
      widx     <= '0;
      mode_out <= mode_after;
      out_d    <= '{target_thread: req.thread_id,
                    event_res: rej ? rwl_pkg::EV_REJECTED : ev,
                    mode_after: mode_after,
                    count: rej ? '0 : rcnt[COUNT_BITS-1:0],
                    last: !(wk_sh_c || wk_ex_c)};
    end else if (cmd.wake_out) begin
      widx  <= widx + AW'(1);
      out_d <= '{target_thread: wentry.thread,
                 event_res: rwl_pkg::EV_WOKEN,
                 mode_after: mode_out,
                 count: wentry.cnt,
                 last: wk_ex || sh_last};
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      big   <= 1'b0;
      lmode <= rwl_pkg::M_UNLOCKED;
      owner <= '0;
      rec   <= '0;
      shr   <= '0;
      ehead <= '0;
      ecnt  <= '0;
      scnt  <= '0;
      pend  <= 1'b0;
      out_v <= 1'b0;
    end else begin
      if (cfg_we) big <= cfg_wdata;
      pend <= issuing;
      if (res_ready) out_v <= 1'b0;
      if (cmd.decide) begin
        out_v <= 1'b1;
        if (!rej) begin
          lmode <= wk_sh_c ? rwl_pkg::M_SHARED : n_mode;
          owner <= n_owner;
          rec   <= n_rec[COUNT_BITS-1:0];
          shr   <= n_shr[COUNT_BITS-1:0];
          if (enq_sh) scnt <= scnt + CW'(1);
          if (enq_ex) ecnt <= ecnt + CW'(1);
        end
      end else if (cmd.wake_out) begin
        out_v <= 1'b1;
        if (wk_ex) begin
          lmode <= rwl_pkg::M_EXCL;
          owner <= ex_rd.thread;
          rec   <= COUNT_BITS'(ex_rd.cnt);
          ehead <= wrap({1'b0, ehead} + (AW+1)'(1));
          ecnt  <= ecnt - CW'(1);
        end else begin
          rec <= sum_rec[COUNT_BITS-1:0];
          shr <= sum_shr[COUNT_BITS-1:0];
          if (sh_last) scnt <= '0;
        end
      end
    end
  end

  always_comb begin
    st.scan_done = (scan_j >= total) && !pend;
    st.wake_any  = wk_sh_c || wk_ex_c;
    st.wake_more = wk_sh && !sh_last;
    st.out_free  = !out_v || res_ready;
  end

  assign res_valid = out_v;
  assign res_data  = out_d;

endmodule

@@ rtl/recursive_rw_lock_manager.sv @@
// Top level of the reader-writer lock manager.
//
// Requests (func, thread_id, restore_count) arrive on the req stream; result
// records leave on the res stream, one or more per request, the final one
// marked by last. big_lock_mode must be written through cfg_we/cfg_wdata
// only while the block is idle; the block itself does not enforce this.
// A request first scans both wait queues for the requester, one entry per
// cycle through a registered read. The decision cycle then loads the first
// result; when no waiter is woken, a new request can be taken the cycle
// after the decision. A final unlock or force release that wakes waiters
// then walks the woken threads, one result each: S_WRD reads the entry
// through the registered read port of the wait queue memory and S_WOUT
// loads the result.
// One request is in flight at a time; req.ready is high only between
// requests. The output register holds a result while res.ready is low and
// the sequencer stalls until it is taken; nothing is dropped.
// Reset (synchronous, rst high) clears the lock state, the queue pointers
// and the register; queue storage needs no clearing.
module recursive_rw_lock_manager #(
  parameter int WAIT_DEPTH = rwl_pkg::WAIT_DEPTH_DEF
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          cfg_we,
  input  logic          cfg_wdata,
  rwl_stream_if.sink    req,
  rwl_stream_if.source  res
);

  rwl_pkg::cmd_t  cmd;
  rwl_pkg::stat_t st;
  rwl_pkg::res_t  res_d;

  rwl_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req.valid),
    .req_ready (req.ready),
    .st        (st),
    .cmd       (cmd)
  );

  rwl_datapath #(
    .WAIT_DEPTH (WAIT_DEPTH)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .req_data  (req.data),
    .res_ready (res.ready),
    .res_valid (res.valid),
    .res_data  (res_d),
    .cmd       (cmd),
    .st        (st)
  );

  assign res.data = res_d;

endmodule

@@ sim/rwl_lock_checker.sv @@
// Lock-state predictor and result checker for the reader-writer lock manager.
module rwl_lock_checker (
  input  logic           clk,
  input  logic           rst,
  input  logic           cfg_we,
  input  logic           cfg_wdata,
  input  logic           req_valid,
  input  logic           req_ready,
  input  rwl_pkg::req_t  req_data,
  input  logic           res_valid,
  input  logic           res_ready,
  input  rwl_pkg::res_t  res_data,
  output int             errors,
  output int             pending,
  output int             results_seen
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int DEPTH = rwl_pkg::WAIT_DEPTH_DEF;
  localparam int CBITS = rwl_pkg::COUNT_BITS_DEF;
  localparam int CMAX  = (1 << CBITS) - 1;

  logic            big_mode;
  logic [1:0]      mode;
  logic [7:0]      owner;
  int              rec_total;
  int              sh_total;
  rwl_pkg::entry_t ex_q[$];
  rwl_pkg::entry_t sh_q[$];
  rwl_pkg::res_t   expected_results[$];
  rwl_pkg::res_t   step_out[$];

  assign pending = expected_results.size();

  task automatic report(input string what, input rwl_pkg::res_t got,
                        input rwl_pkg::res_t want);
    errors++;
    $display("mismatch %s: got %0d/%0d/%0d/%0d/%0d want %0d/%0d/%0d/%0d/%0d",
      what, got.target_thread, got.event_res, got.mode_after, got.count, got.last,
      want.target_thread, want.event_res, want.mode_after, want.count, want.last);
  endtask

  function automatic void put(input logic [7:0] thr, input logic [2:0] ev, input int cnt);
    rwl_pkg::res_t r;
    r = '0;
    r.target_thread = thr;
    r.event_res = ev;
    r.count = cnt[CBITS-1:0];
    step_out.push_back(r);
  endfunction

  function automatic int sat(input int a, input int b);
    return (a + b > CMAX) ? CMAX : a + b;
  endfunction

  function automatic bit waiting(input logic [7:0] thr);
    foreach (sh_q[i]) if (sh_q[i].thread == thr) return 1;
    foreach (ex_q[i]) if (ex_q[i].thread == thr) return 1;
    return 0;
  endfunction

  function automatic bit wake_sh();
    if (sh_q.size() == 0) return 0;
    mode = rwl_pkg::M_SHARED;
    foreach (sh_q[i]) begin
      sh_total = sat(sh_total, sh_q[i].cnt);
      rec_total = sat(rec_total, sh_q[i].cnt);
      put(sh_q[i].thread, rwl_pkg::EV_WOKEN, sh_q[i].cnt);
    end
    sh_q.delete();
    return 1;
  endfunction

  function automatic bit wake_ex();
    rwl_pkg::entry_t w;
    if (ex_q.size() == 0) return 0;
    w = ex_q.pop_front();
    mode = rwl_pkg::M_EXCL;
    owner = w.thread;
    rec_total = w.cnt;
    put(w.thread, rwl_pkg::EV_WOKEN, w.cnt);
    return 1;
  endfunction

  function automatic void wake_waiters(input bit was_excl);
    if (big_mode) void'(wake_ex());
    else if (was_excl) begin
      if (!wake_sh()) void'(wake_ex());
    end else begin
      if (!wake_ex()) void'(wake_sh());
    end
  endfunction

  function automatic bit enqueue(input bit to_sh, input logic [7:0] thr, input int cnt);
    rwl_pkg::entry_t e;
    e.thread = thr;
    e.cnt = cnt[CBITS-1:0];
    if (to_sh) begin
      if (sh_q.size() >= DEPTH) return 0;
      sh_q.push_back(e);
    end else begin
      if (ex_q.size() >= DEPTH) return 0;
      ex_q.push_back(e);
    end
    return 1;
  endfunction

  function automatic void predict_request(input rwl_pkg::req_t rq);
    bit rej;
    bit excl;
    bit was_excl;
    int saved;
    int lc;
    rej = 0;
    lc = rq.restore_count;
    step_out.delete();
    if (rq.func > rwl_pkg::F_RESTORE || rq.thread_id == 0 || waiting(rq.thread_id)) rej = 1;
    else if (rq.func == rwl_pkg::F_LOCK_SH || rq.func == rwl_pkg::F_LOCK_EX) begin
      excl = (rq.func == rwl_pkg::F_LOCK_EX);
      if (!excl && big_mode) rej = 1;
      else if (mode == rwl_pkg::M_UNLOCKED) begin
        mode = excl ? rwl_pkg::M_EXCL : rwl_pkg::M_SHARED;
        owner = excl ? rq.thread_id : 8'd0;
        sh_total = excl ? 0 : 1;
        rec_total = 1;
        put(rq.thread_id, rwl_pkg::EV_GRANTED, rec_total);
      end else if (mode == rwl_pkg::M_EXCL && owner == rq.thread_id) begin
        if (rec_total >= CMAX) rej = 1;
        else begin
          rec_total++;
          put(rq.thread_id, rwl_pkg::EV_GRANTED, rec_total);
        end
      end else if (mode == rwl_pkg::M_SHARED && !excl) begin
        if (rec_total >= CMAX || sh_total >= CMAX) rej = 1;
        else begin
          rec_total++;
          sh_total++;
          put(rq.thread_id, rwl_pkg::EV_GRANTED, rec_total);
        end
      end else if (!enqueue(!excl && !big_mode, rq.thread_id, 1)) rej = 1;
      else put(rq.thread_id, rwl_pkg::EV_BLOCKED, 1);
    end else if (rq.func == rwl_pkg::F_UNLOCK) begin
      if (mode == rwl_pkg::M_UNLOCKED ||
          (mode == rwl_pkg::M_EXCL && owner != rq.thread_id)) rej = 1;
      else begin
        was_excl = (mode == rwl_pkg::M_EXCL);
        if (rec_total > 0) rec_total--;
        if (!was_excl && sh_total > 0) sh_total--;
        put(rq.thread_id, rwl_pkg::EV_RELEASED, rec_total);
        if (rec_total == 0) begin
          owner = 0;
          sh_total = 0;
          mode = rwl_pkg::M_UNLOCKED;
          wake_waiters(was_excl);
        end
      end
    end else if (rq.func == rwl_pkg::F_FORCE) begin
      if (!big_mode || mode == rwl_pkg::M_SHARED) rej = 1;
      else if (mode == rwl_pkg::M_EXCL && owner == rq.thread_id) begin
        saved = rec_total;
        owner = 0;
        rec_total = 0;
        mode = rwl_pkg::M_UNLOCKED;
        put(rq.thread_id, rwl_pkg::EV_FORCE, saved);
        wake_waiters(1);
      end else put(rq.thread_id, rwl_pkg::EV_FORCE, 0);
    end else begin
      if (!big_mode || lc == 0 || mode == rwl_pkg::M_SHARED) rej = 1;
      else if (mode == rwl_pkg::M_UNLOCKED) begin
        mode = rwl_pkg::M_EXCL;
        owner = rq.thread_id;
        sh_total = 0;
        rec_total = lc;
        put(rq.thread_id, rwl_pkg::EV_GRANTED, rec_total);
      end else if (owner == rq.thread_id) begin
        if (rec_total + lc > CMAX) rej = 1;
        else begin
          rec_total += lc;
          put(rq.thread_id, rwl_pkg::EV_GRANTED, rec_total);
        end
      end else if (!enqueue(0, rq.thread_id, lc)) rej = 1;
      else put(rq.thread_id, rwl_pkg::EV_BLOCKED, lc);
    end
    if (rej) begin
      step_out.delete();
      put(rq.thread_id, rwl_pkg::EV_REJECTED, 0);
    end
    foreach (step_out[i]) begin
      step_out[i].mode_after = mode;
      step_out[i].last = (i == step_out.size() - 1);
      expected_results.push_back(step_out[i]);
    end
  endfunction

  always @(posedge clk) begin
    rwl_pkg::res_t want;
    if (rst) begin
      big_mode <= 0;
      mode = rwl_pkg::M_UNLOCKED;
      owner = 0;
      rec_total = 0;
      sh_total = 0;
      ex_q.delete();
      sh_q.delete();
      expected_results.delete();
      errors = 0;
      results_seen = 0;
    end else begin
      if (cfg_we) big_mode <= cfg_wdata;
      if (res_valid && res_ready) begin
        results_seen++;
        if (expected_results.size() == 0) report("unexpected", res_data, '0);
        else begin
          want = expected_results.pop_front();
          if (res_data.target_thread != want.target_thread) report("thread", res_data, want);
          else if (res_data.event_res != want.event_res) report("event", res_data, want);
          else if (res_data.mode_after != want.mode_after) report("mode", res_data, want);
          else if (res_data.count != want.count) report("count", res_data, want);
          else if (res_data.last != want.last) report("last", res_data, want);
        end
      end
      if (req_valid && req_ready) predict_request(req_data);
    end
  end
endmodule

@@ sim/recursive_rw_lock_manager_tb.sv @@
// Stimulus and verdict for the reader-writer lock manager.
module recursive_rw_lock_manager_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int LIMIT = 400000;

  logic clk = 0;
  logic rst = 1;
  logic cfg_we = 0;
  logic cfg_wdata = 0;
  int   errors, pending, results_seen;
  int   cycles = 0;
  bit   hold_off = 0;
  int   sent = 0;

  rwl_stream_if #(.T(rwl_pkg::req_t)) req ();
  rwl_stream_if #(.T(rwl_pkg::res_t)) res ();

  recursive_rw_lock_manager uut (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .req(req.sink), .res(res.source)
  );

  rwl_lock_checker chk (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .req_valid(req.valid), .req_ready(req.ready), .req_data(req.data),
    .res_valid(res.valid), .res_ready(res.ready), .res_data(res.data),
    .errors(errors), .pending(pending), .results_seen(results_seen)
  );

  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("FAILED: results differ");
      $finish;
    end
  end

  // Result side: random stall per result, long hold while hold_off.
  initial begin
    int w;
    res.ready = 0;
    @(negedge rst);
    forever begin
      w = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 13) : 0;
      repeat (w) begin
        res.ready <= 0;
        @(posedge clk);
      end
      while (hold_off) begin
        res.ready <= 0;
        @(posedge clk);
      end
      res.ready <= 1;
      @(posedge clk);
      while (!res.valid) @(posedge clk);
    end
  end

  // Valid stays up after the handshake; callers that pause drop it.
  task automatic send(input logic [2:0] f, input logic [7:0] thr, input logic [15:0] lc);
    int w;
    w = ($urandom_range(0, 2) == 0) ? $urandom_range(0, 13) : 0;
    if (w != 0) begin
      req.valid <= 0;
      repeat (w) @(posedge clk);
    end
    req.valid <= 1;
    req.data <= '{func: f, thread_id: thr, restore_count: lc};
    @(posedge clk);
    while (!req.ready) @(posedge clk);
    sent++;
  endtask

  task automatic settle_and_set(input logic big);
    req.valid <= 0;
    while (pending != 0) @(posedge clk);
    repeat (60) @(posedge clk);
    cfg_we <= 1;
    cfg_wdata <= big;
    @(posedge clk);
    cfg_we <= 0;
    @(posedge clk);
  endtask

  // Mostly well-formed lock/unlock traffic from a small thread pool.
  task automatic random_phase(input int n);
    logic [2:0] f;
    logic [7:0] thr;
    logic [15:0] lc;
    int r;
    repeat (n) begin
      r = $urandom_range(0, 99);
      thr = ($urandom_range(0, 9) == 0) ? 8'($urandom) : 8'($urandom_range(1, 6));
      lc = ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(0, 4));
      if (r < 30) f = rwl_pkg::F_LOCK_SH;
      else if (r < 55) f = rwl_pkg::F_LOCK_EX;
      else if (r < 85) f = rwl_pkg::F_UNLOCK;
      else if (r < 90) f = rwl_pkg::F_FORCE;
      else if (r < 96) f = rwl_pkg::F_RESTORE;
      else f = 3'($urandom_range(5, 7));
      send(f, thr, lc);
    end
  endtask

  initial begin
    req.valid = 0;
    req.data = '0;
    repeat (6) @(posedge clk);
    rst <= 0;
    @(posedge clk);
    // Directed: grants, nesting, queueing, wake order, misuse.
    send(rwl_pkg::F_LOCK_SH, 8'd1, 16'd0);
    send(rwl_pkg::F_LOCK_SH, 8'd2, 16'd0);
    send(rwl_pkg::F_LOCK_EX, 8'd3, 16'd0);
    send(rwl_pkg::F_LOCK_EX, 8'd3, 16'd0);
    send(rwl_pkg::F_UNLOCK, 8'd1, 16'd0);
    send(rwl_pkg::F_UNLOCK, 8'd2, 16'd0);
    send(rwl_pkg::F_LOCK_SH, 8'd4, 16'd0);
    send(rwl_pkg::F_LOCK_SH, 8'd3, 16'd0);
    send(rwl_pkg::F_UNLOCK, 8'd3, 16'd0);
    send(rwl_pkg::F_UNLOCK, 8'd9, 16'd0);
    send(rwl_pkg::F_UNLOCK, 8'd3, 16'd0);
    send(rwl_pkg::F_UNLOCK, 8'd4, 16'd0);
    send(rwl_pkg::F_UNLOCK, 8'd4, 16'd0);
    send(3'd7, 8'd255, 16'hFFFF);
    send(rwl_pkg::F_LOCK_EX, 8'd0, 16'd0);
    send(rwl_pkg::F_FORCE, 8'd5, 16'd0);
    send(rwl_pkg::F_RESTORE, 8'd5, 16'd3);
    settle_and_set(1);
    send(rwl_pkg::F_RESTORE, 8'd7, 16'hFFFE);
    send(rwl_pkg::F_LOCK_EX, 8'd7, 16'd0);
    send(rwl_pkg::F_LOCK_EX, 8'd7, 16'd0);
    send(rwl_pkg::F_RESTORE, 8'd8, 16'd0);
    send(rwl_pkg::F_RESTORE, 8'd8, 16'hFFFF);
    send(rwl_pkg::F_LOCK_SH, 8'd9, 16'd0);
    send(rwl_pkg::F_FORCE, 8'd9, 16'd0);
    send(rwl_pkg::F_FORCE, 8'd7, 16'd0);
    send(rwl_pkg::F_FORCE, 8'd8, 16'd0);
    settle_and_set(0);
    // Fill the shared queue past depth under an exclusive holder.
    send(rwl_pkg::F_LOCK_EX, 8'd100, 16'd0);
    hold_off = 1;
    fork
      begin
        repeat (300) @(posedge clk);
        hold_off = 0;
      end
      begin
        for (int t = 101; t < 119; t++) send(rwl_pkg::F_LOCK_SH, 8'(t), 16'd0);
        send(rwl_pkg::F_UNLOCK, 8'd100, 16'd0);
      end
    join
    for (int t = 101; t < 117; t++) send(rwl_pkg::F_UNLOCK, 8'(t), 16'd0);
    random_phase(100);
    settle_and_set(1);
    random_phase(80);
    settle_and_set(0);
    random_phase(80);
    req.valid <= 0;
    while (pending != 0) @(posedge clk);
    repeat (60) @(posedge clk);
    $display("sent %0d requests in regular and big-lock phases, checked %0d results",
      sent, results_seen);
    if (errors == 0) $display("PASSED: all results match");
    else $display("FAILED: results differ");
    $finish;
  end
endmodule
